// ----- rtl/bounded_list_insert_delete_defines.svh -----
// assertion macros for the bounded list block
`ifndef BOUNDED_LIST_INSERT_DELETE_DEFINES_SVH
`define BOUNDED_LIST_INSERT_DELETE_DEFINES_SVH

// property checked only while out of reset
`define BLI_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bounded list check failed");

// property checked at every edge, reset included
`define BLI_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("bounded list check failed during reset");

`endif

// ----- rtl/bli_pkg.sv -----
// shared types and codes for the bounded list block
package bli_pkg;

    localparam logic [1:0] OP_INS_FRONT = 2'd0;
    localparam logic [1:0] OP_INS_BACK  = 2'd1;
    localparam logic [1:0] OP_DELETE    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_NOPOS = 2'd3;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 16;
    localparam int COUNT_W = 5;

    typedef struct packed {
        logic                ins_front;
        logic                ins_back;
        logic                del;
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    idx;
        logic [POS_W-1:0]    count;
    } bli_cmd_t;

endpackage

// ----- rtl/bli_cell.sv -----
// one storage cell of the list chain
module bli_cell #(
    parameter int INDEX = 0
) (
    input  logic                         clk,
    input  bli_pkg::bli_cmd_t            cmd,
    input  logic [bli_pkg::VALUE_W-1:0]  left_value,
    input  logic [bli_pkg::VALUE_W-1:0]  right_value,
    output logic [bli_pkg::VALUE_W-1:0]  cell_value,
    output logic [bli_pkg::VALUE_W-1:0]  tap
);

    localparam logic [bli_pkg::POS_W-1:0] MY_IDX = bli_pkg::POS_W'(INDEX);

    logic [bli_pkg::VALUE_W-1:0] value_reg;
    logic [bli_pkg::VALUE_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins_front)
        begin
            value_next = (INDEX == 0) ? cmd.value : left_value;
        end
        else if (cmd.ins_back && (cmd.count == MY_IDX))
        begin
            value_next = cmd.value;
        end
        else if (cmd.del && (MY_IDX >= cmd.idx))
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign cell_value = value_reg;
    assign tap        = (cmd.idx == MY_IDX) ? value_reg : '0;

endmodule

// ----- rtl/bli_chain.sv -----
// row of list cells with neighbor links and removal tap
module bli_chain #(
    parameter int CAPACITY = 16
) (
    input  logic                         clk,
    input  bli_pkg::bli_cmd_t            cmd,
    output logic [bli_pkg::VALUE_W-1:0]  picked_value
);

    logic [bli_pkg::VALUE_W-1:0] values [CAPACITY];
    logic [bli_pkg::VALUE_W-1:0] taps   [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [bli_pkg::VALUE_W-1:0] left_v;
        logic [bli_pkg::VALUE_W-1:0] right_v;

        if (i == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_mid_l
            assign left_v = values[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_mid_r
            assign right_v = values[i+1];
        end

        bli_cell #(
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .left_value  (left_v),
            .right_value (right_v),
            .cell_value  (values[i]),
            .tap         (taps[i])
        );
    end

    always_comb
    begin
        picked_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            picked_value = picked_value | taps[i];
        end
    end

endmodule

// ----- rtl/bounded_list_insert_delete.sv -----
// top level of the bounded ordered list with front/back insert and delete
//
// input channel: in_valid / in_ready carries one request word with
// operation, value and position. output channel: out_valid / out_ready
// carries one result word with status, removed_value and element_count.
// every request gives exactly one result.
// the result appears in the cycle after the request is accepted.
// throughput: one request per cycle unless out_ready stalls; all cells
// shift in the same cycle that the request is taken, so nothing iterates.
// the removed value is picked from the row by a gated or-reduction over
// all cells.
// in_ready is high while the output register is empty or being drained,
// so a stalled receiver holds the result and blocks only new requests.
// reset clears the element count and the output valid; cell contents are
// left as they are and are never read before being written.
module bounded_list_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          operation,
    input  logic signed [bli_pkg::VALUE_W-1:0]  value,
    input  logic [bli_pkg::POS_W-1:0]           position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic signed [bli_pkg::VALUE_W-1:0]  removed_value,
    output logic [bli_pkg::COUNT_W-1:0]         element_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic                         out_valid_reg;
    logic [1:0]                   status_reg;
    logic [1:0]                   status_next;
    logic [bli_pkg::VALUE_W-1:0]  removed_reg;
    logic [bli_pkg::VALUE_W-1:0]  removed_next;
    logic [bli_pkg::COUNT_W-1:0]  ecount_reg;

    logic                         accept;
    logic [bli_pkg::POS_W-1:0]    count16;
    logic [bli_pkg::POS_W-1:0]    del_idx;
    logic [bli_pkg::VALUE_W-1:0]  picked_value;
    bli_pkg::bli_cmd_t            cmd;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign count16  = bli_pkg::POS_W'(count_reg);
    assign del_idx  = (position == '0) ? '0 : position - 1'b1;

    always_comb
    begin
        cmd.ins_front = 1'b0;
        cmd.ins_back  = 1'b0;
        cmd.del       = 1'b0;
        cmd.value     = value;
        cmd.idx       = del_idx;
        cmd.count     = count16;
        status_next   = bli_pkg::ST_OK;
        removed_next  = '0;
        count_next    = count_reg;
        case (operation)
            bli_pkg::OP_INS_FRONT,
            bli_pkg::OP_INS_BACK:
            begin
                if (count16 >= bli_pkg::POS_W'(CAPACITY))
                begin
                    status_next = bli_pkg::ST_FULL;
                end
                else
                begin
                    cmd.ins_front = accept && (operation == bli_pkg::OP_INS_FRONT);
                    cmd.ins_back  = accept && (operation == bli_pkg::OP_INS_BACK);
                    count_next    = count_reg + 1'b1;
                end
            end
            bli_pkg::OP_DELETE:
            begin
                if (count_reg == '0)
                begin
                    status_next = bli_pkg::ST_EMPTY;
                end
                else if (del_idx >= count16)
                begin
                    status_next = bli_pkg::ST_NOPOS;
                end
                else
                begin
                    cmd.del      = accept;
                    removed_next = picked_value;
                    count_next   = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = bli_pkg::ST_OK;
            end
        endcase
    end

    bli_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .clk          (clk),
        .cmd          (cmd),
        .picked_value (picked_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            ecount_reg  <= bli_pkg::COUNT_W'(count_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign element_count = ecount_reg;

endmodule

// ----- rtl/bli_checker.sv -----
// port-level checks for the bounded list block and its bind
`include "bounded_list_insert_delete_defines.svh"

module bli_checker #(
    parameter int CAPACITY = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [1:0]                          status,
    input logic signed [bli_pkg::VALUE_W-1:0]  removed_value,
    input logic [bli_pkg::COUNT_W-1:0]         element_count
);

    logic [bli_pkg::COUNT_W+bli_pkg::VALUE_W+1:0] result_word;
    logic                                         full_seen;
    logic                                         refused;
    logic                                         empty_ok;

    assign result_word = {status, removed_value, element_count};
    assign full_seen   = out_valid && (status == bli_pkg::ST_FULL);
    assign refused     = out_valid && (status != bli_pkg::ST_OK);
    assign empty_ok    = (status != bli_pkg::ST_EMPTY) || (element_count == '0);

    `BLI_ASSERT(a_accept_gives_result, (in_valid && in_ready) |=> out_valid)
    `BLI_ASSERT(a_stall_holds, (out_valid && !out_ready) |=> (out_valid && $stable(result_word)))
    `BLI_ASSERT(a_full_count, full_seen |-> (element_count == bli_pkg::COUNT_W'(CAPACITY)))
    `BLI_ASSERT(a_refused_no_value, refused |-> ((removed_value == '0) && empty_ok))
    `BLI_ASSERT_ALWAYS(a_reset_empty_output, !rst_n |=> !out_valid)

endmodule

bind bounded_list_insert_delete bli_checker #(.CAPACITY(CAPACITY)) u_bli_checker (.*);
